// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file srb_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SRB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SRB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/srb_pkg.sv -----
// ----------------------------------------------------------------------------
// srb_pkg
// Types and constants of the sequence reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

   localparam int DEPTH_DEF    = 16;
   localparam int SEQ_BITS_DEF = 16;

   localparam int SEQ_W  = 16;
   localparam int DATA_W = 32;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [SEQ_W-1:0]  seq;
      logic [DATA_W-1:0] data;
   } cmd_type;

endpackage

`default_nettype wire

// ----- src/sequence_reorder_buffer.sv -----
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Keeps up to DEPTH frames ordered by sequence number; writes, head reads
// and clears come in on one request channel, one response per request.
// ----------------------------------------------------------------------------
// Request channel (req_*): operation write, read or clear with sequence
// number and frame data. Response channel (rsp_*): status, popped frame
// and occupancy after the request.
// Requests enter a two-entry queue; unless a stalled response holds it,
// the cell row takes one request per cycle from that queue and inserts by
// compare-and-shift across all cells, so throughput is one request per clock.
// An accepted request is held in a queue slot, then its response is
// registered in the response register and sits there while rsp_stall is high;
// the queue keeps taking requests until both entries are held, then
// raises req_stall.
// Reset empties the buffer, forgets the start sequence and drops any
// queued request or pending response; frame cells are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_reorder_buffer #(
   parameter int DEPTH    = srb_pkg::DEPTH_DEF,
   parameter int SEQ_BITS = srb_pkg::SEQ_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_operation,
   input  wire logic [srb_pkg::SEQ_W-1:0]  req_seq_num,
   input  wire logic [srb_pkg::DATA_W-1:0] req_frame_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [srb_pkg::SEQ_W-1:0]       rsp_out_seq_num,
   output logic [srb_pkg::DATA_W-1:0]      rsp_out_frame_data,
   output logic [srb_pkg::OCC_W-1:0]       rsp_occupancy
);

   srb_pkg::cmd_type req_cmd;
   srb_pkg::cmd_type q_cmd;
   logic             q_valid;
   logic             q_take;

   assign req_cmd.op   = req_operation;
   assign req_cmd.seq  = req_seq_num;
   assign req_cmd.data = req_frame_data;

   srb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_cmd    (req_cmd),
      .out_valid (q_valid),
      .out_take  (q_take),
      .out_cmd   (q_cmd)
   );

   srb_back #(
      .DEPTH    (DEPTH),
      .SEQ_BITS (SEQ_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (q_valid),
      .cmd                (q_cmd),
      .cmd_take           (q_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_out_seq_num    (rsp_out_seq_num),
      .rsp_out_frame_data (rsp_out_frame_data),
      .rsp_occupancy      (rsp_occupancy)
   );

endmodule

`default_nettype wire

// ----- src/srb_front.sv -----
// ----------------------------------------------------------------------------
// srb_front
// Two-entry command queue between the request port and the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire srb_pkg::cmd_type  in_cmd,
   output logic                   out_valid,
   input  wire logic              out_take,
   output srb_pkg::cmd_type       out_cmd
);

   srb_pkg::cmd_type slot_ff [2];
   srb_pkg::cmd_type slot_in [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push;
   logic             pop;

   assign in_stall  = (fill_ff == 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ptr_ff];

   assign push = in_valid && !in_stall;
   assign pop  = out_take && out_valid;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = in_cmd;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/srb_back.sv -----
// ----------------------------------------------------------------------------
// srb_back
// Ordered row of frame cells with shifting insert and pop, and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_back #(
   parameter int DEPTH    = srb_pkg::DEPTH_DEF,
   parameter int SEQ_BITS = srb_pkg::SEQ_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       cmd_valid,
   input  wire srb_pkg::cmd_type           cmd,
   output logic                            cmd_take,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [srb_pkg::SEQ_W-1:0]       rsp_out_seq_num,
   output logic [srb_pkg::DATA_W-1:0]      rsp_out_frame_data,
   output logic [srb_pkg::OCC_W-1:0]       rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [SEQ_BITS-1:0]       seq_ff  [DEPTH];
   logic [SEQ_BITS-1:0]       seq_in  [DEPTH];
   logic [srb_pkg::DATA_W-1:0] data_ff [DEPTH];
   logic [srb_pkg::DATA_W-1:0] data_in [DEPTH];

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                seen_ff, seen_in;
   logic [SEQ_BITS-1:0] start_ff, start_in;
   logic [SEQ_BITS-1:0] tail_ff, tail_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  status_ff, status_in;
   logic [srb_pkg::SEQ_W-1:0]   oseq_ff, oseq_in;
   logic [srb_pkg::DATA_W-1:0]  odata_ff, odata_in;

   logic [SEQ_BITS-1:0] new_seq;
   logic                is_full;
   logic                is_empty;
   logic                append;
   logic [DEPTH-1:0]    not_greater;
   logic [CNT_W-1:0]    ins_pos;
   logic                do_insert;
   logic                do_pop;

   assign cmd_take = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign new_seq  = SEQ_BITS'(cmd.seq);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign append   = (tail_ff < new_seq) || ((tail_ff > start_ff) && (new_seq <= start_ff));

   // Each cell compares against the new sequence; the tail takes no part.
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         not_greater[j] = ((j + 1) < int'(count_ff)) && (seq_ff[j] <= new_seq);
      end
   end

   always_comb begin
      ins_pos = '0;
      if (is_empty) begin
         ins_pos = '0;
      end else if (append) begin
         ins_pos = count_ff;
      end else begin
         for (int j = 0; j < DEPTH; j++) begin
            if (not_greater[j]) begin
               ins_pos = CNT_W'(j + 1);
            end
         end
      end
   end

   always_comb begin
      do_insert    = 1'b0;
      do_pop       = 1'b0;
      count_in     = count_ff;
      seen_in      = seen_ff;
      start_in     = start_ff;
      tail_in      = tail_ff;
      status_in    = srb_pkg::ST_OK;
      oseq_in      = '0;
      odata_in     = '0;
      if (cmd_take) begin
         unique case (cmd.op)
            srb_pkg::OP_WRITE: begin
               if (is_full) begin
                  status_in = srb_pkg::ST_FULL;
               end else begin
                  do_insert = 1'b1;
                  count_in  = count_ff + 1'b1;
                  if (!seen_ff) begin
                     seen_in  = 1'b1;
                     start_in = new_seq;
                  end
                  if (is_empty || append) begin
                     tail_in = new_seq;
                  end
               end
            end
            srb_pkg::OP_READ: begin
               if (is_empty) begin
                  status_in = srb_pkg::ST_EMPTY;
               end else begin
                  do_pop   = 1'b1;
                  oseq_in  = srb_pkg::SEQ_W'(seq_ff[0]);
                  odata_in = data_ff[0];
                  count_in = count_ff - 1'b1;
               end
            end
            srb_pkg::OP_CLEAR: begin
               count_in = '0;
               seen_in  = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Shift the row up behind the insert point, or down on a pop.
   always_comb begin
      seq_in  = seq_ff;
      data_in = data_ff;
      if (do_insert) begin
         for (int k = 1; k < DEPTH; k++) begin
            if (CNT_W'(k) > ins_pos) begin
               seq_in[k]  = seq_ff[k-1];
               data_in[k] = data_ff[k-1];
            end
         end
         for (int k = 0; k < DEPTH; k++) begin
            if (CNT_W'(k) == ins_pos) begin
               seq_in[k]  = new_seq;
               data_in[k] = cmd.data;
            end
         end
      end
      if (do_pop) begin
         for (int k = 0; k < DEPTH - 1; k++) begin
            seq_in[k]  = seq_ff[k+1];
            data_in[k] = data_ff[k+1];
         end
      end
   end

   always_comb begin
      if (cmd_take) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff   <= seq_in;
      data_ff  <= data_in;
      start_ff <= start_in;
      tail_ff  <= tail_in;
      if (cmd_take) begin
         status_ff <= status_in;
         oseq_ff   <= oseq_in;
         odata_ff  <= odata_in;
      end
      if (reset) begin
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Occupancy is latched with the rest of the response.
   logic [srb_pkg::OCC_W-1:0] occ_ff;

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         occ_ff <= srb_pkg::OCC_W'(count_in);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_seq_num    = oseq_ff;
   assign rsp_out_frame_data = odata_ff;
   assign rsp_occupancy      = occ_ff;

endmodule

`default_nettype wire

// ----- src/srb_checker.sv -----
// ----------------------------------------------------------------------------
// srb_checker
// Port-level checks of the sequence reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srb_checker #(
   parameter int DEPTH = srb_pkg::DEPTH_DEF
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [1:0]                 rsp_status,
   input wire logic [srb_pkg::SEQ_W-1:0]  rsp_out_seq_num,
   input wire logic [srb_pkg::DATA_W-1:0] rsp_out_frame_data,
   input wire logic [srb_pkg::OCC_W-1:0]  rsp_occupancy
);

   localparam logic [srb_pkg::OCC_W-1:0] FULL_OCC = srb_pkg::OCC_W'(DEPTH);

   `SRB_ASSERT_ALWAYS(a_idle_after_reset, reset |=> !rsp_valid, "response valid after reset")
   `SRB_ASSERT(a_hold_on_stall, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_frame_data), "stalled response changed")
   `SRB_ASSERT(a_empty_read, rsp_valid && (rsp_status == srb_pkg::ST_EMPTY) |-> (rsp_occupancy == '0) && (rsp_out_seq_num == '0) && (rsp_out_frame_data == '0), "empty read with data")
   `SRB_ASSERT(a_full_drop, rsp_valid && (rsp_status == srb_pkg::ST_FULL) |-> (rsp_occupancy == FULL_OCC), "drop while not full")

endmodule

bind sequence_reorder_buffer srb_checker #(.DEPTH(DEPTH)) u_srb_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_status         (rsp_status),
   .rsp_out_seq_num    (rsp_out_seq_num),
   .rsp_out_frame_data (rsp_out_frame_data),
   .rsp_occupancy      (rsp_occupancy)
);

`default_nettype wire
